// File: rtl/asgr_pkg.sv
package asgr_pkg;

  localparam int MaxParamsDef = 8;
  localparam int ParamBitsDef = 16;

  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgDefFg = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDefBg = CfgIdxW'(1);

  localparam logic [31:0] DefFgReset = 32'hFFFF_FFFF;
  localparam logic [31:0] DefBgReset = 32'h0000_0000;

  localparam logic [7:0] CharEsc  = 8'h1B;
  localparam logic [7:0] CharLbr  = 8'h5B;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharM    = 8'h6D;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam int SgrReset   = 0;
  localparam int SgrFgLo    = 30;
  localparam int SgrFgHi    = 37;
  localparam int SgrFgRgb   = 38;
  localparam int SgrBgRgb   = 48;
  localparam int SgrRgbMode = 2;
  localparam int RgbSkip    = 5;

  typedef enum logic [1:0] {
    ST_TEXT,
    ST_ESC,
    ST_CSI,
    ST_WALK
  } asgr_state_e;

  typedef struct packed {
    logic emit;
    logic clear_params;
    logic acc_digit;
    logic next_param;
    logic start_walk;
    logic walk_step;
  } asgr_cmd_t;

  typedef struct packed {
    logic is_esc;
    logic is_lbr;
    logic is_digit;
    logic is_semi;
    logic is_m;
    logic walk_last;
    logic out_busy;
  } asgr_sts_t;

  function automatic logic [31:0] basic_colour(input logic [2:0] sel);
    logic [31:0] c;
    case (sel)
      3'd0:    c = 32'hFF00_0000;
      3'd1:    c = 32'hFFFF_0000;
      3'd2:    c = 32'hFF00_FF00;
      3'd3:    c = 32'hFFFF_FF00;
      3'd4:    c = 32'hFF00_00FF;
      3'd5:    c = 32'hFFFF_00FF;
      3'd6:    c = 32'hFF00_FFFF;
      default: c = 32'hFFFF_FFFF;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ansi_sgr_colour_parser_top.sv
// output: a text character other than ESC is registered and shows at the output in the cycle after it is taken
// throughput: one item a cycle, held while an output item waits unaccepted or a parameter walk runs
// the final 'm' of a colour sequence holds input for the walk, one walk step per parameter,
//   up to MAX_PARAMS, where a 38;2 or 48;2 group of five is one step
// the walk goes through a parameter shift line
// reset: asynchronous, active low; colours and defaults return to reset values
module ansi_sgr_colour_parser_top #(
  parameter int MAX_PARAMS = asgr_pkg::MaxParamsDef,
  parameter int PARAM_BITS = asgr_pkg::ParamBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [asgr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   char_code_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   glyph_code_o,
  output logic [31:0]                  glyph_foreground_o,
  output logic [31:0]                  glyph_background_o
);

  asgr_pkg::asgr_cmd_t cmd;
  asgr_pkg::asgr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  asgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asgr_dp #(
    .MAX_PARAMS (MAX_PARAMS),
    .PARAM_BITS (PARAM_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .char_code_i        (char_code_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .glyph_code_o       (glyph_code_o),
    .glyph_foreground_o (glyph_foreground_o),
    .glyph_background_o (glyph_background_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(out_valid_o && !out_ready_i))
    else $error("item taken while output is stalled");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("emitted item missing at output");

  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_walk |=> !in_ready_o)
    else $error("input taken during parameter walk");

  a_param_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.acc_digit || cmd.next_param || cmd.clear_params) |-> (in_valid_i && in_ready_o))
    else $error("parameter update without an item");

endmodule

// File: rtl/asgr_ctrl.sv
module asgr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  asgr_pkg::asgr_sts_t sts_i,
  output asgr_pkg::asgr_cmd_t cmd_o
);

  asgr_pkg::asgr_state_e state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q != asgr_pkg::ST_WALK) && !sts_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asgr_pkg::ST_TEXT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      asgr_pkg::ST_TEXT: begin
        if (accept && sts_i.is_esc) state_d = asgr_pkg::ST_ESC;
      end
      asgr_pkg::ST_ESC: begin
        if (accept) state_d = sts_i.is_lbr ? asgr_pkg::ST_CSI : asgr_pkg::ST_TEXT;
      end
      asgr_pkg::ST_CSI: begin
        if (accept && !sts_i.is_digit && !sts_i.is_semi) begin
          state_d = sts_i.is_m ? asgr_pkg::ST_WALK : asgr_pkg::ST_TEXT;
        end
      end
      asgr_pkg::ST_WALK: begin
        if (sts_i.walk_last) state_d = asgr_pkg::ST_TEXT;
      end
      default: state_d = asgr_pkg::ST_TEXT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      asgr_pkg::ST_TEXT: begin
        cmd_o.emit = accept && !sts_i.is_esc;
      end
      asgr_pkg::ST_ESC: begin
        cmd_o.clear_params = accept && sts_i.is_lbr;
      end
      asgr_pkg::ST_CSI: begin
        cmd_o.acc_digit  = accept && sts_i.is_digit;
        cmd_o.next_param = accept && sts_i.is_semi;
        cmd_o.start_walk = accept && sts_i.is_m;
      end
      asgr_pkg::ST_WALK: begin
        cmd_o.walk_step = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/asgr_dp.sv
module asgr_dp #(
  parameter int MAX_PARAMS = asgr_pkg::MaxParamsDef,
  parameter int PARAM_BITS = asgr_pkg::ParamBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [asgr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic [7:0]                   char_code_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [7:0]                   glyph_code_o,
  output logic [31:0]                  glyph_foreground_o,
  output logic [31:0]                  glyph_background_o,
  input  asgr_pkg::asgr_cmd_t          cmd_i,
  output asgr_pkg::asgr_sts_t          sts_o
);

  localparam int IdxW = $clog2(MAX_PARAMS);
  localparam int CntW = $clog2(MAX_PARAMS + 1);
  localparam int AccW = PARAM_BITS + 4;

  logic [31:0] def_fg_q, def_bg_q, cur_fg_q, cur_fg_d, cur_bg_q, cur_bg_d;
  logic [PARAM_BITS-1:0] par_q [MAX_PARAMS];
  logic [PARAM_BITS-1:0] par_d [MAX_PARAMS];
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q;
  logic [7:0]  code_q;
  logic [31:0] ofg_q, obg_q;

  logic [AccW-1:0] acc_wide;
  logic [PARAM_BITS-1:0] acc_sat, head;
  logic is_rgb_fg, is_rgb_bg, is_rgb;
  logic [CntW-1:0] step;

  // character decode
  assign sts_o.is_esc   = (char_code_i == asgr_pkg::CharEsc);
  assign sts_o.is_lbr   = (char_code_i == asgr_pkg::CharLbr);
  assign sts_o.is_semi  = (char_code_i == asgr_pkg::CharSemi);
  assign sts_o.is_m     = (char_code_i == asgr_pkg::CharM);
  assign sts_o.is_digit = (char_code_i >= asgr_pkg::CharZero) &&
                          (char_code_i <= asgr_pkg::CharNine);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // saturating decimal accumulate
  assign acc_wide = ({4'b0, par_q[idx_q]} << 3) + ({4'b0, par_q[idx_q]} << 1) +
                    AccW'(char_code_i[3:0]);
  assign acc_sat  = (acc_wide > {4'b0, {PARAM_BITS{1'b1}}}) ? {PARAM_BITS{1'b1}} :
                    acc_wide[PARAM_BITS-1:0];

  // walk head of the parameter shift line
  assign head      = par_q[0];
  assign is_rgb_fg = (head == PARAM_BITS'(asgr_pkg::SgrFgRgb)) &&
                     (par_q[1] == PARAM_BITS'(asgr_pkg::SgrRgbMode));
  assign is_rgb_bg = (head == PARAM_BITS'(asgr_pkg::SgrBgRgb)) &&
                     (par_q[1] == PARAM_BITS'(asgr_pkg::SgrRgbMode));
  assign is_rgb    = is_rgb_fg || is_rgb_bg;
  assign step      = is_rgb ? CntW'(asgr_pkg::RgbSkip) : CntW'(1);
  assign sts_o.walk_last = (cnt_q <= step);

  always_comb begin
    par_d    = par_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    cur_fg_d = cur_fg_q;
    cur_bg_d = cur_bg_q;
    if (cmd_i.clear_params) begin
      for (int j = 0; j < MAX_PARAMS; j++) par_d[j] = '0;
      idx_d = '0;
    end
    if (cmd_i.acc_digit) par_d[idx_q] = acc_sat;
    if (cmd_i.next_param && (idx_q < IdxW'(MAX_PARAMS - 1))) idx_d = idx_q + IdxW'(1);
    if (cmd_i.start_walk) cnt_d = CntW'(idx_q) + CntW'(1);
    if (cmd_i.walk_step) begin
      cnt_d = cnt_q - step;
      if (head == PARAM_BITS'(asgr_pkg::SgrReset)) begin
        cur_fg_d = def_fg_q;
        cur_bg_d = def_bg_q;
      end else if ((head >= PARAM_BITS'(asgr_pkg::SgrFgLo)) &&
                   (head <= PARAM_BITS'(asgr_pkg::SgrFgHi))) begin
        cur_fg_d = asgr_pkg::basic_colour(3'(head - PARAM_BITS'(asgr_pkg::SgrFgLo)));
      end else if (is_rgb_fg) begin
        cur_fg_d = {8'h00, par_q[2][7:0], par_q[3][7:0], par_q[4][7:0]};
      end else if (is_rgb_bg) begin
        cur_bg_d = {8'h00, par_q[2][7:0], par_q[3][7:0], par_q[4][7:0]};
      end
      // shift the line, zeros fill in from the far end
      if (is_rgb) begin
        for (int j = 0; j < MAX_PARAMS; j++) begin
          par_d[j] = (j + asgr_pkg::RgbSkip < MAX_PARAMS) ?
                     par_q[(j + asgr_pkg::RgbSkip) % MAX_PARAMS] : '0;
        end
      end else begin
        for (int j = 0; j < MAX_PARAMS; j++) begin
          par_d[j] = (j + 1 < MAX_PARAMS) ? par_q[(j + 1) % MAX_PARAMS] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fg_q    <= asgr_pkg::DefFgReset;
      def_bg_q    <= asgr_pkg::DefBgReset;
      cur_fg_q    <= asgr_pkg::DefFgReset;
      cur_bg_q    <= asgr_pkg::DefBgReset;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_PARAMS; j++) par_q[j] <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == asgr_pkg::CfgDefFg)) def_fg_q <= cfg_data_i;
      if (cfg_valid_i && (cfg_index_i == asgr_pkg::CfgDefBg)) def_bg_q <= cfg_data_i;
      cur_fg_q <= cur_fg_d;
      cur_bg_q <= cur_bg_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      par_q    <= par_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      code_q <= char_code_i;
      ofg_q  <= cur_fg_q;
      obg_q  <= cur_bg_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign glyph_code_o       = code_q;
  assign glyph_foreground_o = ofg_q;
  assign glyph_background_o = obg_q;

endmodule
